### rtl/pic_pkg.sv
package pic_pkg;

    // Number of interrupt sources that are wired up (8 to 64).
    localparam int NUM_SOURCES = 64;

    // Vectors are always stored at full width.
    localparam int VEC_W       = 64;
    localparam int SRC_W       = 6;
    localparam int LEVEL_W     = 3;
    localparam int DATA_W      = 32;
    localparam int OFFSET_W    = 8;
    localparam int SIZE_W      = 3;

    // Priority search: groups of sources, reduced in two registered stages.
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = VEC_W / GROUP_SIZE;

    localparam logic [VEC_W-1:0] SRC_MASK = {VEC_W{1'b1}} >> (VEC_W - NUM_SOURCES);

    // Bus commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access sizes in bytes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_3B   = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    // Register offsets
    localparam logic [OFFSET_W-1:0] OFF_PEND_HI  = 8'h00;
    localparam logic [OFFSET_W-1:0] OFF_PEND_LO  = 8'h04;
    localparam logic [OFFSET_W-1:0] OFF_MASK_HI  = 8'h08;
    localparam logic [OFFSET_W-1:0] OFF_MASK_LO  = 8'h0c;
    localparam logic [OFFSET_W-1:0] OFF_FORCE_HI = 8'h10;
    localparam logic [OFFSET_W-1:0] OFF_FORCE_LO = 8'h14;
    localparam logic [OFFSET_W-1:0] OFF_WORD_END = 8'h18;
    localparam logic [OFFSET_W-1:0] OFF_SET_MASK = 8'h1c;
    localparam logic [OFFSET_W-1:0] OFF_CLR_MASK = 8'h1d;
    localparam logic [OFFSET_W-1:0] OFF_LEVEL    = 8'h40;
    localparam logic [OFFSET_W-1:0] OFF_LEVEL_END = 8'h80;

    // Bit positions in the set/clear mask byte
    localparam int ALL_BIT = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_MERGE,
        ST_OUT
    } pic_state_t;

    typedef struct packed {
        logic load;
        logic group_en;
        logic merge_en;
    } pic_cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SRC_W-1:0]   src;
    } pic_cand_t;

endpackage

### rtl/pic_ctrl.sv
module pic_ctrl
    import pic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output pic_cmd_t cmd
);

    pic_state_t state_reg;
    pic_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd.load     = 1'b0;
        cmd.group_en = 1'b0;
        cmd.merge_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GROUP;
                end
            end
            ST_GROUP:
            begin
                cmd.group_en = 1'b1;
                state_next   = ST_MERGE;
            end
            ST_MERGE:
            begin
                cmd.merge_en = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pic_datapath.sv
module pic_datapath
    import pic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pic_cmd_t            cmd,
    input  logic                command,
    input  logic [OFFSET_W-1:0] offset,
    input  logic [SIZE_W-1:0]   access_size,
    input  logic [DATA_W-1:0]   write_data,
    input  logic [VEC_W-1:0]    source_lines,
    output logic [DATA_W-1:0]   read_data,
    output logic                irq_valid,
    output logic [LEVEL_W-1:0]  irq_level,
    output logic [SRC_W-1:0]    irq_source,
    output logic [VEC_W-1:0]    new_forced
);

    logic [VEC_W-1:0]   mask_reg;
    logic [VEC_W-1:0]   mask_next;
    logic [VEC_W-1:0]   force_reg;
    logic [VEC_W-1:0]   force_next;
    logic [LEVEL_W-1:0] level_reg [VEC_W];

    logic [VEC_W-1:0]   lines_reg;
    logic [DATA_W-1:0]  rd_reg;
    logic [VEC_W-1:0]   newf_reg;
    pic_cand_t          group_reg [NUM_GROUPS];
    pic_cand_t          group_next [NUM_GROUPS];
    pic_cand_t          best_reg;
    pic_cand_t          best_next;

    logic [VEC_W-1:0]   lines_in;
    logic [DATA_W-1:0]  rd_value;
    logic               is_write;
    logic               level_hit;
    logic               level_wr;
    logic [SRC_W-1:0]   level_idx;
    logic [VEC_W-1:0]   pend;

    function automatic logic [DATA_W-1:0] all_ones(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] r;
        priority if (size >= SIZE_WORD) r = {DATA_W{1'b1}};
        else if (size == SIZE_3B)       r = 32'h00ff_ffff;
        else if (size == SIZE_HALF)     r = 32'h0000_ffff;
        else if (size == SIZE_BYTE)     r = 32'h0000_00ff;
        else                            r = '0;
        return r;
    endfunction

    assign lines_in  = source_lines & SRC_MASK;
    assign is_write  = (command == CMD_WRITE);
    assign level_idx = offset[SRC_W-1:0];
    assign level_hit = (offset >= OFF_LEVEL) && (offset < OFF_LEVEL_END)
                       && ({1'b0, level_idx} < (SRC_W+1)'(NUM_SOURCES))
                       && (access_size == SIZE_BYTE);
    assign level_wr  = cmd.load && is_write && level_hit;

    // Register read
    always_comb
    begin
        logic [VEC_W-1:0] raw;
        raw = lines_in | force_reg;
        if ((offset < OFF_WORD_END) && (access_size == SIZE_WORD))
        begin
            unique case (offset)
                OFF_PEND_HI:  rd_value = raw[63:32];
                OFF_PEND_LO:  rd_value = raw[31:0];
                OFF_MASK_HI:  rd_value = mask_reg[63:32];
                OFF_MASK_LO:  rd_value = mask_reg[31:0];
                OFF_FORCE_HI: rd_value = force_reg[63:32];
                OFF_FORCE_LO: rd_value = force_reg[31:0];
                default:      rd_value = '0;
            endcase
        end
        else if (level_hit)
        begin
            rd_value = {{(DATA_W-LEVEL_W){1'b0}}, level_reg[level_idx]};
        end
        else
        begin
            rd_value = all_ones(access_size);
        end
    end

    // Register write
    always_comb
    begin
        mask_next  = mask_reg;
        force_next = force_reg;
        if (cmd.load && is_write)
        begin
            priority if (access_size == SIZE_WORD && offset == OFF_MASK_HI)
                mask_next[63:32] = write_data;
            else if (access_size == SIZE_WORD && offset == OFF_MASK_LO)
                mask_next[31:0] = write_data;
            else if (access_size == SIZE_WORD && offset == OFF_FORCE_HI)
                force_next[63:32] = write_data;
            else if (access_size == SIZE_WORD && offset == OFF_FORCE_LO)
                force_next[31:0] = write_data;
            else if (access_size == SIZE_BYTE && offset == OFF_SET_MASK)
            begin
                if (write_data[ALL_BIT])
                    mask_next = {VEC_W{1'b1}};
                else
                    mask_next = mask_reg | (VEC_W'(1) << write_data[SRC_W-1:0]);
            end
            else if (access_size == SIZE_BYTE && offset == OFF_CLR_MASK)
            begin
                // Clearing any single bit also drops mask-all
                if (write_data[ALL_BIT])
                    mask_next = '0;
                else
                    mask_next = mask_reg & ~((VEC_W'(1) << write_data[SRC_W-1:0])
                                             | VEC_W'(1));
            end
            else
            begin
                mask_next = mask_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= {VEC_W{1'b1}};
            force_reg <= '0;
            for (int i = 0; i < VEC_W; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else
        begin
            mask_reg  <= mask_next;
            force_reg <= force_next;
            if (level_wr)
            begin
                level_reg[level_idx] <= write_data[LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lines_reg <= lines_in;
            rd_reg    <= is_write ? '0 : rd_value;
            newf_reg  <= force_next & ~force_reg;
        end
    end

    // Pending set from the updated state; source 0 never wins
    always_comb
    begin
        pend    = (lines_reg & ~mask_reg) & {VEC_W{~mask_reg[0]}};
        pend    = (pend | force_reg) & SRC_MASK;
        pend[0] = 1'b0;
    end

    // First stage: best candidate in each group, lowest source on a tie
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (pend[g*GROUP_SIZE+k]
                    && level_reg[g*GROUP_SIZE+k] > group_next[g].level)
                begin
                    group_next[g].level = level_reg[g*GROUP_SIZE+k];
                    group_next[g].src   = SRC_W'(g*GROUP_SIZE+k);
                end
            end
        end
    end

    // Second stage: best over the groups
    always_comb
    begin
        best_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (group_reg[g].level > best_next.level)
            begin
                best_next = group_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.group_en)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
        if (cmd.merge_en)
        begin
            best_reg <= best_next;
        end
    end

    assign read_data  = rd_reg;
    assign irq_valid  = (best_reg.level != '0);
    assign irq_level  = best_reg.level;
    assign irq_source = best_reg.src;
    assign new_forced = newf_reg;

endmodule

### rtl/priority_interrupt_controller.sv
// Register-mapped interrupt controller for 64 sources. Each input word is one
// bus access (read or write, tuser = command) carrying the raw source lines; the
// access is applied first, then the highest nonzero level among the pending
// sources 1..63 is reported (lowest source number wins a tie), together with
// the read data and the force bits newly set by the access. The accept cycle
// applies the access, then two registered stages of the priority tree
// (eight groups of eight sources, then the eight group winners) produce the
// result, which is held until taken. The next access is accepted in the cycle
// after the result is taken.
module priority_interrupt_controller
    import pic_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // offset[7:0], access_size[10:8], write_data[42:11], source_lines[106:43], zero
    input  logic [111:0] s_tdata,
    // command[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[31:0], irq_valid[32], irq_level[35:33], irq_source[41:36],
    // new_forced[105:42], zero
    output logic [111:0] m_tdata
);

    pic_cmd_t           cmd;
    logic [DATA_W-1:0]  read_data;
    logic               irq_valid;
    logic [LEVEL_W-1:0] irq_level;
    logic [SRC_W-1:0]   irq_source;
    logic [VEC_W-1:0]   new_forced;

    pic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pic_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .command      (s_tuser),
        .offset       (s_tdata[7:0]),
        .access_size  (s_tdata[10:8]),
        .write_data   (s_tdata[42:11]),
        .source_lines (s_tdata[106:43]),
        .read_data    (read_data),
        .irq_valid    (irq_valid),
        .irq_level    (irq_level),
        .irq_source   (irq_source),
        .new_forced   (new_forced)
    );

    assign m_tdata = {6'b0, new_forced, irq_source, irq_level, irq_valid, read_data};

endmodule

### rtl/pic_checker.sv
module pic_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    // One access in flight: no accept while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // A result never shows in the cycle after an accept
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result appeared too early");

    a_valid_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32] == (m_tdata[35:33] != 3'd0)))
        else $error("irq_valid disagrees with irq_level");

    a_no_irq_src: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[32]) |-> (m_tdata[41:36] == 6'd0))
        else $error("source reported without an interrupt");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/pic_scoreboard.sv
package pic_tb_pkg;

    import pic_pkg::*;

    // One result word as it leaves the controller, lowest field in the lowest bits.
    typedef struct packed {
        logic [VEC_W-1:0]   new_forced;
        logic [SRC_W-1:0]   irq_source;
        logic [LEVEL_W-1:0] irq_level;
        logic               irq_valid;
        logic [DATA_W-1:0]  read_data;
    } pic_reply_t;

    localparam int REPLY_W = $bits(pic_reply_t);

    class pic_scoreboard;

        logic [VEC_W-1:0]   mask_reg;
        logic [VEC_W-1:0]   force_reg;
        logic [LEVEL_W-1:0] level_reg [VEC_W];

        pic_reply_t awaited_replies [$];

        int unsigned failures;
        int unsigned replies_checked;
        int unsigned reads_seen;
        int unsigned writes_seen;
        int unsigned irqs_seen;
        int unsigned new_force_seen;

        function new();
            mask_reg  = '1;
            force_reg = '0;
            foreach (level_reg[i])
                level_reg[i] = '0;
            failures        = 0;
            replies_checked = 0;
            reads_seen      = 0;
            writes_seen     = 0;
            irqs_seen       = 0;
            new_force_seen  = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_replies.size();
        endfunction

        // Apply one accepted bus access to the shadow registers and queue its reply.
        function void note_access(logic cmd, logic [OFFSET_W-1:0] off, logic [SIZE_W-1:0] sz,
                                  logic [DATA_W-1:0] wd, logic [VEC_W-1:0] lines);
            pic_reply_t       r;
            logic [VEC_W-1:0] live;
            logic [VEC_W-1:0] prior;
            logic [VEC_W-1:0] seen;
            logic [VEC_W-1:0] pend;
            logic             level_hit;
            int               s;

            r         = '0;
            live      = lines & SRC_MASK;
            level_hit = off >= OFF_LEVEL && off < OFF_LEVEL_END && sz == SIZE_BYTE
                        && int'(off - OFF_LEVEL) < NUM_SOURCES;

            if (cmd == CMD_WRITE)
            begin
                writes_seen++;
                prior = force_reg;
                if (sz == SIZE_WORD && off == OFF_MASK_HI)
                    mask_reg[63:32] = wd;
                else if (sz == SIZE_WORD && off == OFF_MASK_LO)
                    mask_reg[31:0] = wd;
                else if (sz == SIZE_WORD && off == OFF_FORCE_HI)
                    force_reg[63:32] = wd;
                else if (sz == SIZE_WORD && off == OFF_FORCE_LO)
                    force_reg[31:0] = wd;
                else if (sz == SIZE_BYTE && off == OFF_SET_MASK)
                begin
                    if (wd[ALL_BIT])
                        mask_reg = '1;
                    else
                        mask_reg[wd[SRC_W-1:0]] = 1'b1;
                end
                else if (sz == SIZE_BYTE && off == OFF_CLR_MASK)
                begin
                    if (wd[ALL_BIT])
                        mask_reg = '0;
                    else
                    begin
                        // a single-bit clear also drops the mask-all bit
                        mask_reg[wd[SRC_W-1:0]] = 1'b0;
                        mask_reg[0] = 1'b0;
                    end
                end
                else if (level_hit)
                    level_reg[off - OFF_LEVEL] = wd[LEVEL_W-1:0];
                r.new_forced = force_reg & ~prior;
            end
            else
            begin
                reads_seen++;
                seen = live | force_reg;
                if (off < OFF_WORD_END && sz == SIZE_WORD)
                begin
                    case (off)
                        OFF_PEND_HI:  r.read_data = seen[63:32];
                        OFF_PEND_LO:  r.read_data = seen[31:0];
                        OFF_MASK_HI:  r.read_data = mask_reg[63:32];
                        OFF_MASK_LO:  r.read_data = mask_reg[31:0];
                        OFF_FORCE_HI: r.read_data = force_reg[63:32];
                        OFF_FORCE_LO: r.read_data = force_reg[31:0];
                        default:      r.read_data = '0;
                    endcase
                end
                else if (level_hit)
                    r.read_data = DATA_W'(level_reg[off - OFF_LEVEL]);
                else if (sz >= SIZE_WORD)
                    r.read_data = '1;
                else
                    r.read_data = (32'd1 << (8 * sz)) - 32'd1;
            end

            pend = mask_reg[0] ? '0 : (live & ~mask_reg);
            pend = (pend | force_reg) & SRC_MASK;
            // source 0 never wins; strict compare keeps the lowest number on a tie
            for (s = 1; s < VEC_W; s++)
            begin
                if (pend[s] && level_reg[s] > r.irq_level)
                begin
                    r.irq_level  = level_reg[s];
                    r.irq_source = SRC_W'(s);
                end
            end
            r.irq_valid = r.irq_level != '0;
            awaited_replies = {awaited_replies, r};
        endfunction

        function void compare_field(string name, logic [VEC_W-1:0] want, logic [VEC_W-1:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [REPLY_W-1:0] word);
            pic_reply_t got;
            pic_reply_t want;

            got = pic_reply_t'(word);
            if (awaited_replies.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result word, expected none, got %h", $time, word);
                return;
            end
            want = awaited_replies.pop_front();
            replies_checked++;
            if (want.irq_valid)
                irqs_seen++;
            if (want.new_forced != '0)
                new_force_seen++;
            compare_field("read_data", VEC_W'(want.read_data), VEC_W'(got.read_data));
            compare_field("irq_valid", VEC_W'(want.irq_valid), VEC_W'(got.irq_valid));
            compare_field("irq_level", VEC_W'(want.irq_level), VEC_W'(got.irq_level));
            compare_field("irq_source", VEC_W'(want.irq_source), VEC_W'(got.irq_source));
            compare_field("new_forced", want.new_forced, got.new_forced);
        endfunction

    endclass

endpackage

### test/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pic_pkg::*;
    import pic_tb_pkg::*;

    localparam int RANDOM_ACCESSES = 700;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // offset[7:0], access_size[10:8], write_data[42:11], source_lines[106:43], zero
    logic [111:0] s_tdata;
    // command[0]
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // read_data[31:0], irq_valid[32], irq_level[35:33], irq_source[41:36],
    // new_forced[105:42], zero
    logic [111:0] m_tdata;

    pic_scoreboard sb;
    logic          calm;

    priority_interrupt_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one access, holding it until the controller takes the word.
    task automatic send_access(input logic cmd, input logic [OFFSET_W-1:0] off,
                               input logic [SIZE_W-1:0] sz, input logic [DATA_W-1:0] wd,
                               input logic [VEC_W-1:0] lines);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, lines, wd, sz, off};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_access(cmd, off, sz, wd, lines);
    endtask

    function automatic logic [VEC_W-1:0] random_lines();
        logic [VEC_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v & {$urandom, $urandom} & {$urandom, $urandom};
            1: v = '1;
            2: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    // Output side: check every taken word, stall at random, and once hold off for long.
    initial
    begin : reply_side
        int   hold;
        logic held_once;

        hold      = 0;
        held_once = 1'b0;
        m_tready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[REPLY_W-1:0]);
            if (!held_once && sb.replies_checked == 150)
            begin
                held_once = 1'b1;
                hold      = 300;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || $urandom_range(0, 99) >= 37;
        end
    end

    initial
    begin : access_side
        int               n;
        int               pick;
        logic [DATA_W-1:0] wd;

        sb       = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_READ;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, misaligned and unmapped reads of every width
        send_access(CMD_READ, OFF_PEND_HI, SIZE_WORD, '1, {$urandom, $urandom});
        send_access(CMD_READ, OFF_PEND_LO, SIZE_WORD, '0, '1);
        send_access(CMD_READ, OFF_MASK_HI, SIZE_WORD, '0, '0);
        send_access(CMD_READ, OFF_FORCE_LO, SIZE_WORD, '0, '1);
        send_access(CMD_READ, OFF_PEND_HI + 8'h02, SIZE_WORD, '0, '1);
        send_access(CMD_READ, OFF_WORD_END, SIZE_WORD, '0, '0);
        send_access(CMD_READ, 8'hff, 3'd0, '0, '0);
        send_access(CMD_READ, 8'h33, SIZE_3B, '0, '0);
        send_access(CMD_READ, 8'h20, 3'd7, '0, '0);
        send_access(CMD_READ, OFF_LEVEL_END, SIZE_BYTE, '0, '0);
        send_access(CMD_READ, OFF_LEVEL, SIZE_HALF, '0, '0);
        // levels: source 0 is never delivered, 5 and 63 tie at the top
        send_access(CMD_WRITE, OFF_LEVEL, SIZE_BYTE, '1, '1);
        send_access(CMD_WRITE, OFF_LEVEL + 8'd63, SIZE_BYTE, 32'h0000_0007, '1);
        send_access(CMD_WRITE, OFF_LEVEL + 8'd5, SIZE_BYTE, 32'hffff_fff7, '1);
        send_access(CMD_WRITE, OFF_LEVEL + 8'd1, SIZE_BYTE, 32'h0000_0003, '1);
        send_access(CMD_READ, OFF_LEVEL + 8'd63, SIZE_BYTE, '0, '1);
        // single clear also drops mask-all, then clear and set whole mask
        send_access(CMD_WRITE, OFF_CLR_MASK, SIZE_BYTE, 32'h0000_003f, '1);
        send_access(CMD_WRITE, OFF_CLR_MASK, SIZE_BYTE, 32'h0000_0040, '1);
        send_access(CMD_WRITE, OFF_SET_MASK, SIZE_BYTE, 32'h0000_0005, '1);
        send_access(CMD_WRITE, OFF_SET_MASK, SIZE_BYTE, 32'h0000_0040, '1);
        // forced sources override mask-all; a repeated force reports nothing new
        send_access(CMD_WRITE, OFF_FORCE_LO, SIZE_WORD, 32'h0000_0022, '0);
        send_access(CMD_WRITE, OFF_FORCE_HI, SIZE_WORD, 32'h8000_0000, '0);
        send_access(CMD_WRITE, OFF_FORCE_LO, SIZE_WORD, 32'h0000_0022, '0);
        send_access(CMD_WRITE, OFF_MASK_LO, SIZE_WORD, 32'hffff_fffe, '1);
        send_access(CMD_WRITE, OFF_MASK_HI, SIZE_WORD, 32'h0000_0000, '1);
        send_access(CMD_WRITE, 8'h30, SIZE_WORD, '1, '1);

        for (n = 0; n < RANDOM_ACCESSES; n++)
        begin
            calm = n >= 300 && n < 420;
            pick = $urandom_range(0, 99);
            wd   = $urandom;
            if (pick < 20)
                send_access(CMD_WRITE, OFF_LEVEL + 8'($urandom_range(0, NUM_SOURCES - 1)),
                            SIZE_BYTE, wd, random_lines());
            else if (pick < 30)
                send_access(CMD_READ, OFF_LEVEL + 8'($urandom_range(0, NUM_SOURCES - 1)),
                            SIZE_BYTE, wd, random_lines());
            else if (pick < 47)
            begin
                // keep the whole-mask forms rare so single-bit updates dominate
                if ($urandom_range(0, 9) != 0)
                    wd[ALL_BIT] = 1'b0;
                send_access(CMD_WRITE, pick < 40 ? OFF_CLR_MASK : OFF_SET_MASK, SIZE_BYTE,
                            wd, random_lines());
            end
            else if (pick < 57)
                send_access(CMD_WRITE, $urandom_range(0, 1) ? OFF_MASK_HI : OFF_MASK_LO,
                            SIZE_WORD, wd, random_lines());
            else if (pick < 67)
            begin
                // mostly sparse force patterns, sometimes clearing everything
                wd = $urandom_range(0, 3) == 0 ? '0 : wd & $urandom & $urandom;
                send_access(CMD_WRITE, $urandom_range(0, 1) ? OFF_FORCE_HI : OFF_FORCE_LO,
                            SIZE_WORD, wd, random_lines());
            end
            else if (pick < 81)
                send_access(CMD_READ, OFF_PEND_HI + 8'(4 * $urandom_range(0, 5)), SIZE_WORD,
                            wd, random_lines());
            else
                send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            3'($urandom_range(0, 7)), wd, random_lines());
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d register accesses (%0d reads, %0d writes) with a long output stall.",
                 sb.reads_seen + sb.writes_seen, sb.reads_seen, sb.writes_seen);
        $display("%0d results carried an interrupt, %0d reported newly forced sources.",
                 sb.irqs_seen, sb.new_force_seen);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
